// File: design/bbse_pkg.sv
package bbse_pkg;

  // Command codes
  localparam logic [3:0] CMD_CLEAR_ALL  = 4'd0;
  localparam logic [3:0] CMD_SET        = 4'd1;
  localparam logic [3:0] CMD_CLEAR      = 4'd2;
  localparam logic [3:0] CMD_TEST       = 4'd3;
  localparam logic [3:0] CMD_OR         = 4'd4;
  localparam logic [3:0] CMD_AND        = 4'd5;
  localparam logic [3:0] CMD_ANDNOT     = 4'd6;
  localparam logic [3:0] CMD_DISJOINT   = 4'd7;
  localparam logic [3:0] CMD_SUBSUME    = 4'd8;
  localparam logic [3:0] CMD_LIST_SET   = 4'd9;
  localparam logic [3:0] CMD_LIST_CLEAR = 4'd10;
  localparam logic [3:0] CMD_COUNT      = 4'd11;

  // Status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOB = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // Register map
  localparam int         CFG_AW   = 3;
  localparam logic       REG_LOW  = 1'b0;
  localparam logic       REG_HIGH = 1'b1;

  localparam int POP_W       = 13;
  localparam int MAX_RESULTS = 32;
  localparam int LIST_CNT_W  = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] elem_index;
    logic [6:0]         word_sel;
    logic [31:0]        operand_word;
    logic               stream_end;
  } bbse_in_t;

  typedef struct packed {
    logic               bit_value;
    logic signed [31:0] listed_index;
    logic               index_valid;
    logic               verdict;
    logic [POP_W-1:0]   population;
    logic [1:0]         status;
    logic               run_last;
  } bbse_out_t;

  typedef enum logic [1:0] {
    EK_PLAIN,
    EK_TEST,
    EK_CHECK,
    EK_LIST
  } bbse_emit_e;

  typedef struct packed {
    logic       clr_begin;
    logic       clr_step;
    logic       div_span;
    logic       geo_ld;
    logic       ld_item;
    logic       addr_word;
    logic       addr_elem;
    logic       mem_rd;
    logic       mod_ld;
    logic       mem_wr;
    logic       check_step;
    logic       check_fold;
    logic       list_ld;
    logic       list_step;
    logic       emit;
    logic       last;
    logic [1:0] status;
    bbse_emit_e kind;
  } bbse_ctl_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       span_ok;
    logic       elem_oob;
    logic       word_bad;
    logic       clr_last;
    logic       list_bit;
    logic       list_rest;
    logic       list_empty;
  } bbse_stat_t;

endpackage

// File: design/bbse_divc.sv
module bbse_divc #(
  parameter int WORD_BITS   = 32,
  parameter int STORE_WORDS = 128
) (
  input  logic                                                    clk_i,
  input  logic [$clog2(STORE_WORDS*WORD_BITS)-1:0]                x_i,
  output logic [((STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1)-1:0] q_o,
  output logic [$clog2(WORD_BITS)-1:0]                            r_o
);
  localparam int XW  = $clog2(STORE_WORDS * WORD_BITS);
  localparam int AW  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int RMW = $clog2(WORD_BITS);
  localparam int SH  = XW + $clog2(WORD_BITS);
  localparam int RW  = XW + 2;
  localparam int PW  = XW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  logic [XW-1:0]  x_q;
  logic [PW-1:0]  prod_q;
  logic [AW-1:0]  q_c, q_q;
  logic [XW-1:0]  r_full;
  logic [RMW-1:0] r_q;

  // floor(x / WORD_BITS) by reciprocal, exact for every x below 2**XW
  assign q_c    = AW'(prod_q >> SH);
  assign r_full = x_q - XW'(XW'(q_c) * XW'(WORD_BITS));

  always_ff @(posedge clk_i) begin
    x_q    <= x_i;
    prod_q <= PW'(x_i) * PW'(RECIP);
    q_q    <= q_c;
    r_q    <= RMW'(r_full);
  end

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

// File: design/bbse_dp.sv
module bbse_dp #(
  parameter int WORD_BITS   = 32,
  parameter int STORE_WORDS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbse_pkg::bbse_ctl_t ctl_i,
  output bbse_pkg::bbse_stat_t stat_o,
  input  bbse_pkg::bbse_in_t  item_i,
  output bbse_pkg::bbse_out_t result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_sel_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                cfg_rsel_i,
  output logic [31:0]         cfg_rdata_o
);
  import bbse_pkg::*;

  localparam int AW       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int RMW      = $clog2(WORD_BITS);
  localparam int XW       = $clog2(STORE_WORDS * WORD_BITS);
  localparam int CW       = (AW > 7) ? AW : 7;
  localparam int SPAN_LIM = STORE_WORDS * WORD_BITS;
  localparam logic [WORD_BITS-1:0] FULL = '1;
  localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(1);

  function automatic logic [6:0] pop64(input logic [63:0] w);
    logic [63:0] v;
    v = w - ((w >> 1) & 64'h5555_5555_5555_5555);
    v = (v & 64'h3333_3333_3333_3333) + ((v >> 2) & 64'h3333_3333_3333_3333);
    v = (v + (v >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
    v = v + (v >> 8);
    v = v + (v >> 16);
    v = v + (v >> 32);
    return v[6:0];
  endfunction

  logic signed [31:0]   low_q, high_q;
  bbse_in_t             item_q;
  logic [AW-1:0]        clr_addr_q, addr_q, last_word_q;
  logic [RMW-1:0]       bitpos_q;
  logic [WORD_BITS-1:0] last_mask_q, rd_q, new_q, old_q, sel_q;
  logic                 span_ok_q;
  logic [POP_W-1:0]     cnt_q, cnt_d;
  logic                 acc_q, acc_d, acc_mid, verdict_c, check_ok;
  logic [31:0]          idx_q;
  bbse_out_t            res_q, res_d;
  logic [WORD_BITS-1:0] mem [STORE_WORDS];

  logic [32:0]          span;
  logic                 span_ok_c;
  logic signed [31:0]   rel;
  logic [XW-1:0]        div_x;
  logic [AW-1:0]        div_q;
  logic [RMW-1:0]       div_r;
  logic [WORD_BITS-1:0] opw, wmask, opb, bitmask, new_c, sel_c;

  assign span      = {high_q[31], high_q} - {low_q[31], low_q};
  assign span_ok_c = !span[32] && (span[31:0] < 32'(SPAN_LIM));
  assign rel       = item_q.elem_index - low_q;
  assign div_x     = ctl_i.div_span ? XW'(span[31:0]) : XW'(rel);

  bbse_divc #(
    .WORD_BITS  (WORD_BITS),
    .STORE_WORDS(STORE_WORDS)
  ) u_div (
    .clk_i(clk_i),
    .x_i  (div_x),
    .q_o  (div_q),
    .r_o  (div_r)
  );

  assign opw     = WORD_BITS'(item_q.operand_word);
  assign wmask   = (addr_q == last_word_q) ? last_mask_q : FULL;
  assign opb     = opw & wmask;
  assign bitmask = ONE << bitpos_q;

  always_comb begin
    case (item_q.cmd)
      CMD_SET:   new_c = rd_q | bitmask;
      CMD_CLEAR: new_c = rd_q & ~bitmask;
      CMD_OR:    new_c = rd_q | opb;
      CMD_AND:   new_c = rd_q & opb;
      default:   new_c = rd_q & ~opb;
    endcase
  end

  assign sel_c    = (item_q.cmd == CMD_LIST_SET) ? rd_q : (~rd_q & wmask);
  assign check_ok = (item_q.cmd == CMD_DISJOINT) ? ((rd_q & opb) == '0)
                                                 : ((opb & ~rd_q) == '0);
  assign acc_mid   = (ctl_i.check_fold && !check_ok) ? 1'b0 : acc_q;
  assign verdict_c = item_q.stream_end ? acc_mid : 1'b0;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr_begin) begin
      acc_d = 1'b1;
    end else if (ctl_i.check_step) begin
      acc_d = item_q.stream_end ? 1'b1 : acc_mid;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.clr_begin) begin
      cnt_d = '0;
    end else if (ctl_i.mem_wr) begin
      cnt_d = cnt_q - POP_W'(pop64(64'(old_q))) + POP_W'(pop64(64'(new_q)));
    end
  end

  always_comb begin
    res_d            = '0;
    res_d.population = cnt_d;
    res_d.status     = ctl_i.status;
    res_d.run_last   = ctl_i.last;
    case (ctl_i.kind)
      EK_TEST:  res_d.bit_value = rd_q[bitpos_q];
      EK_CHECK: res_d.verdict   = verdict_c;
      EK_LIST: begin
        res_d.listed_index = idx_q;
        res_d.index_valid  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= '0;
      high_q     <= 32'sd4095;
      clr_addr_q <= '0;
      cnt_q      <= '0;
      acc_q      <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        if (cfg_sel_i == REG_HIGH) begin
          high_q <= cfg_wdata_i;
        end else begin
          low_q <= cfg_wdata_i;
        end
      end
      if (ctl_i.clr_begin) begin
        clr_addr_q <= '0;
      end else if (ctl_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      cnt_q <= cnt_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_item) begin
      item_q <= item_i;
    end
    if (ctl_i.geo_ld) begin
      last_word_q <= div_q;
      last_mask_q <= FULL >> (RMW'(WORD_BITS - 1) - div_r);
      span_ok_q   <= span_ok_c;
    end
    if (ctl_i.addr_word) begin
      addr_q <= AW'(item_q.word_sel);
    end else if (ctl_i.addr_elem) begin
      addr_q   <= div_q;
      bitpos_q <= div_r;
    end
    if (ctl_i.mod_ld) begin
      new_q <= new_c;
      old_q <= rd_q;
    end
    if (ctl_i.list_ld) begin
      sel_q <= sel_c;
      idx_q <= low_q + 32'(item_q.word_sel) * 32'(WORD_BITS);
    end else if (ctl_i.list_step) begin
      sel_q <= sel_q >> 1;
      idx_q <= idx_q + 32'd1;
    end
    if (ctl_i.emit) begin
      res_q <= res_d;
    end
  end

  // single write port shared by the clearing sweep and the read-modify-write
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_step) begin
      mem[clr_addr_q] <= '0;
    end else if (ctl_i.mem_wr) begin
      mem[addr_q] <= new_q;
    end
    if (ctl_i.mem_rd) begin
      rd_q <= mem[addr_q];
    end
  end

  assign stat_o.cmd        = item_q.cmd;
  assign stat_o.span_ok    = span_ok_q;
  assign stat_o.elem_oob   = (item_q.elem_index < low_q) || (item_q.elem_index > high_q);
  assign stat_o.word_bad   = CW'(item_q.word_sel) > CW'(last_word_q);
  assign stat_o.clr_last   = clr_addr_q == AW'(STORE_WORDS - 1);
  assign stat_o.list_bit   = sel_q[0];
  assign stat_o.list_rest  = |sel_q[WORD_BITS-1:1];
  assign stat_o.list_empty = sel_q == '0;

  assign result_o    = res_q;
  assign cfg_rdata_o = (cfg_rsel_i == REG_HIGH) ? high_q : low_q;

endmodule

// File: design/bbse_ctrl.sv
module bbse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 cfg_we_i,
  input  bbse_pkg::bbse_stat_t stat_i,
  output bbse_pkg::bbse_ctl_t  ctl_o,
  output logic                 busy_o,
  output logic                 strobe_o
);
  import bbse_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_GEO_A,
    S_GEO_B,
    S_GEO_C,
    S_IDLE,
    S_DISPATCH,
    S_DIV_WAIT,
    S_DIV_DONE,
    S_READ,
    S_MODIFY,
    S_WRITE,
    S_LIST
  } state_e;

  state_e                state_q, state_d;
  logic                  pend_q, pend_d;
  logic [LIST_CNT_W-1:0] n_q, n_d;
  logic                  strobe_q;
  logic [3:0]            op;

  function automatic bbse_ctl_t reply(input bbse_emit_e kind, input logic [1:0] st);
    bbse_ctl_t r;
    r        = '0;
    r.emit   = 1'b1;
    r.last   = 1'b1;
    r.kind   = kind;
    r.status = st;
    return r;
  endfunction

  assign op = stat_i.cmd;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    pend_d  = pend_q;
    n_d     = n_q;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_GEO_A;
        end
      end
      S_GEO_A: begin
        ctl_o.div_span = 1'b1;
        state_d        = S_GEO_B;
      end
      S_GEO_B: state_d = S_GEO_C;
      S_GEO_C: begin
        if (pend_q) begin
          ctl_o  = reply(EK_PLAIN, ST_OK);
          pend_d = 1'b0;
        end
        ctl_o.geo_ld = 1'b1;
        state_d      = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.ld_item = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (op == CMD_CLEAR_ALL) begin
          ctl_o.clr_begin = 1'b1;
          pend_d          = 1'b1;
          state_d         = S_CLEAR;
        end else if (op >= CMD_COUNT) begin
          ctl_o   = reply(EK_PLAIN, ST_OK);
          state_d = S_IDLE;
        end else if (!stat_i.span_ok) begin
          ctl_o   = reply(EK_PLAIN, ST_BAD);
          state_d = S_IDLE;
        end else if (op <= CMD_TEST) begin
          if (stat_i.elem_oob) begin
            ctl_o   = reply(EK_PLAIN, ST_OOB);
            state_d = S_IDLE;
          end else begin
            state_d = S_DIV_WAIT;
          end
        end else if (stat_i.word_bad) begin
          if (op == CMD_DISJOINT || op == CMD_SUBSUME) begin
            // no fold, but a stream end still reports and rearms
            ctl_o            = reply(EK_CHECK, ST_BAD);
            ctl_o.check_step = 1'b1;
          end else begin
            ctl_o = reply(EK_PLAIN, ST_BAD);
          end
          state_d = S_IDLE;
        end else begin
          ctl_o.addr_word = 1'b1;
          state_d         = S_READ;
        end
      end
      S_DIV_WAIT: state_d = S_DIV_DONE;
      S_DIV_DONE: begin
        ctl_o.addr_elem = 1'b1;
        state_d         = S_READ;
      end
      S_READ: begin
        ctl_o.mem_rd = 1'b1;
        state_d      = S_MODIFY;
      end
      S_MODIFY: begin
        if (op == CMD_TEST) begin
          ctl_o   = reply(EK_TEST, ST_OK);
          state_d = S_IDLE;
        end else if (op == CMD_DISJOINT || op == CMD_SUBSUME) begin
          ctl_o            = reply(EK_CHECK, ST_OK);
          ctl_o.check_step = 1'b1;
          ctl_o.check_fold = 1'b1;
          state_d          = S_IDLE;
        end else if (op == CMD_LIST_SET || op == CMD_LIST_CLEAR) begin
          ctl_o.list_ld = 1'b1;
          n_d           = '0;
          state_d       = S_LIST;
        end else begin
          ctl_o.mod_ld = 1'b1;
          state_d      = S_WRITE;
        end
      end
      S_WRITE: begin
        ctl_o        = reply(EK_PLAIN, ST_OK);
        ctl_o.mem_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_LIST: begin
        if (stat_i.list_empty) begin
          ctl_o   = reply(EK_PLAIN, ST_OK);
          state_d = S_IDLE;
        end else if (stat_i.list_bit) begin
          ctl_o      = reply(EK_LIST, ST_OK);
          ctl_o.last = !stat_i.list_rest || (n_q == LIST_CNT_W'(MAX_RESULTS - 1));
          n_d        = n_q + LIST_CNT_W'(1);
          if (ctl_o.last) begin
            state_d = S_IDLE;
          end
        end
        ctl_o.list_step = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
    // a register write empties the set and redoes the span geometry
    if (cfg_we_i) begin
      ctl_o           = '0;
      ctl_o.clr_begin = 1'b1;
      pend_d          = 1'b0;
      state_d         = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      pend_q   <= 1'b0;
      n_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      n_q      <= n_d;
      strobe_q <= ctl_o.emit;
    end
  end

  assign busy_o   = state_q != S_IDLE;
  assign strobe_o = strobe_q;

endmodule

// File: design/bounded_bit_set_engine_unit.sv
// Bit set over element indices low_index..high_index, one word of WORD_BITS per memory row.
// Command channel: an item is taken on a clock edge with start high, busy low and no register write.
// Result channel: each word appears on result_o as result_strobe_o goes high for one cycle;
// run_last marks the final word of an item. The receiver cannot stall, so no result waits.
// States from acceptance until busy falls (the final result strobe rises at that edge):
//   count, unused codes, every error reply: DISPATCH (a new item waits for busy to fall)
//   disjoint / subsume fold: DISPATCH, READ, MODIFY; word OR / AND / AND-NOT: then WRITE
//   element test: DISPATCH, DIV_WAIT, DIV_DONE, READ, MODIFY; element set / clear: then WRITE
//   (constant divider pipeline, then one read-modify-write on the store)
//   set / clear listing: DISPATCH, READ, MODIFY, then LIST, one cycle per bit scanned
//   clear all: DISPATCH, CLEAR (one row zeroed per cycle), then GEO_A, GEO_B, GEO_C
// Reset and every register write run the same clearing pass: busy stays high while
// the store is zeroed (CLEAR) and the span is re-divided (GEO_A to GEO_C).
// Registers sit on an APB port at byte 0 (low_index) and 4 (high_index); pready is tied high.
module bounded_bit_set_engine_unit #(
  parameter int WORD_BITS   = 32,
  parameter int STORE_WORDS = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  bbse_pkg::bbse_in_t       item_i,
  output logic                     result_strobe_o,
  output bbse_pkg::bbse_out_t      result_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [bbse_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import bbse_pkg::*;

  bbse_ctl_t  ctl;
  bbse_stat_t stat;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  bbse_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cfg_we_i(cfg_we),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy),
    .strobe_o(result_strobe_o)
  );

  bbse_dp #(
    .WORD_BITS  (WORD_BITS),
    .STORE_WORDS(STORE_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .item_i     (item_i),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we),
    .cfg_sel_i  (paddr[CFG_AW-1]),
    .cfg_wdata_i(pwdata),
    .cfg_rsel_i (paddr[CFG_AW-1]),
    .cfg_rdata_o(prdata)
  );

`ifndef ASSERT_OFF
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> busy)
    else $error("register write did not start the clearing pass");

  a_no_early_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_strobe_o)
    else $error("result word in the cycle after acceptance");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && result_strobe_o) |-> result_o.run_last)
    else $error("engine went idle before the final result word");
`endif

endmodule
